/* rtl/core/uvs_pkg.sv */
// ----------------------------------------------------------------------------
// UV sphere package
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int CordicSteps = 20;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [16:0] One14 = 17'sd16384;

  typedef enum logic [2:0] {
    PH_TOP  = 3'd0,
    PH_RING = 3'd1,
    PH_BOT  = 3'd2,
    PH_TFAN = 3'd3,
    PH_BAND = 3'd4,
    PH_BFAN = 3'd5,
    PH_DONE = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_INDEX  = 2'd1,
    KIND_DONE   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CFG_RADIUS = 2'd0,
    CFG_SLICES = 2'd1,
    CFG_STACKS = 2'd2
  } cfg_idx_t;

  // Sequencer states of the top level.
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_DTH, S_DPH, S_DU, S_DV, S_CTH, S_CPH,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_OUT
  } seq_t;

  // Request to the shared divider: numerator / denominator.
  typedef struct packed {
    logic        start;
    logic [39:0] num;
    logic [7:0]  den;
  } div_req_t;

  function automatic logic [29:0] atan_turn(input logic [4:0] k);
    logic [29:0] r;
    begin
      case (k)
        5'd0:  r = 30'd536870912;
        5'd1:  r = 30'd316933406;
        5'd2:  r = 30'd167458907;
        5'd3:  r = 30'd85004756;
        5'd4:  r = 30'd42667331;
        5'd5:  r = 30'd21354465;
        5'd6:  r = 30'd10679838;
        5'd7:  r = 30'd5340245;
        5'd8:  r = 30'd2670163;
        5'd9:  r = 30'd1335087;
        5'd10: r = 30'd667544;
        5'd11: r = 30'd333772;
        5'd12: r = 30'd166886;
        5'd13: r = 30'd83443;
        5'd14: r = 30'd41722;
        5'd15: r = 30'd20861;
        5'd16: r = 30'd10430;
        5'd17: r = 30'd5215;
        5'd18: r = 30'd2608;
        5'd19: r = 30'd1304;
        default: r = 30'd0;
      endcase
      return r;
    end
  endfunction

endpackage

/* rtl/core/uv_sphere_mesh_generator.sv */
// ----------------------------------------------------------------------------
// UV sphere mesh generator
// One record per request: vertices, then triangle corner indices, then done.
// ----------------------------------------------------------------------------
// A ring vertex needs four divisions (theta, phi, u and v) on one shared
// serial divider, two CORDIC passes on one shared rotator, and five
// multiplies on one shared 17x17 multiplier; a pole or index record skips
// them. The block takes no new request until the record is accepted. Write
// configuration only while no record is in flight; it applies to the next
// record.
module uv_sphere_mesh_generator
  import uvs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic signed [16:0] pos_x,
  output logic signed [16:0] pos_y,
  output logic signed [16:0] pos_z,
  output logic signed [15:0] nrm_x,
  output logic signed [15:0] nrm_y,
  output logic signed [15:0] nrm_z,
  output logic signed [15:0] tan_x,
  output logic signed [15:0] tan_z,
  output logic [16:0]        tex_u,
  output logic [16:0]        tex_v,
  output logic [15:0]        vertex_index,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  seq_t   st, st_next;
  phase_t phase;
  logic [7:0] ring_counter, slice_counter;
  logic [2:0] corner_counter;
  logic [15:0] radius;
  logic [7:0]  slice_count, stack_count;

  logic [7:0] n, sk;
  assign n  = (slice_count < 8'd3) ? 8'd3 : slice_count;
  assign sk = (stack_count < 8'd2) ? 8'd2 : stack_count;

  assign cfg_ready = 1'b1;
  assign in_ready  = (st == S_IDLE);

  // divider
  div_req_t    dreq;
  logic        dbusy;
  logic [39:0] dq;
  uvs_div u_div (.clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .quot(dq));

  // cordic
  logic               cstart, cbusy;
  logic [31:0]        cang;
  logic signed [16:0] ccos, csin;
  uvs_cordic u_cordic (.clk(clk), .rst(rst), .start(cstart), .angle(cang),
                       .busy(cbusy), .cos_o(ccos), .sin_o(csin));

  logic        started;
  logic [31:0] th, ph;
  logic signed [16:0] ct, stt, cp, sp, nx, nz;
  logic signed [16:0] ma, mb;
  logic signed [33:0] mp;
  logic signed [33:0] rnd;
  assign mp  = ma * mb;
  assign rnd = (mp + 34'sd8192) >>> 14;

  // output register
  logic [1:0]         o_kind;
  logic signed [16:0] o_px, o_py, o_pz;
  logic signed [15:0] o_nx, o_ny, o_nz, o_tx, o_tz;
  logic [16:0]        o_u, o_v;
  logic [15:0]        o_idx;

  // corner index
  logic [15:0] rvc, a_i, b_i, south, base, cidx;
  always_comb begin
    rvc   = 16'(n) + 16'd1;
    a_i   = 16'd1 + 16'(ring_counter) * rvc + 16'(slice_counter);
    b_i   = a_i + rvc;
    south = 16'd1 + 16'(sk - 8'd1) * rvc;
    base  = south - rvc;
    cidx  = 16'd0;
    unique case (phase)
      PH_TFAN: cidx = (corner_counter == 3'd0) ? 16'd0 :
                      (corner_counter == 3'd1) ? 16'(slice_counter) + 16'd2
                                                : 16'(slice_counter) + 16'd1;
      PH_BAND: begin
        case (corner_counter)
          3'd0: cidx = a_i;
          3'd1, 3'd4: cidx = a_i + 16'd1;
          3'd2, 3'd3: cidx = b_i;
          default: cidx = b_i + 16'd1;
        endcase
      end
      default: cidx = (corner_counter == 3'd0) ? south :
                      (corner_counter == 3'd1) ? base + 16'(slice_counter)
                                                : base + 16'(slice_counter) + 16'd1;
    endcase
  end

  // sequencer
  always_comb begin
    st_next = st;
    dreq    = '0;
    cstart  = 1'b0;
    cang    = th;
    ma      = '0;
    mb      = '0;
    unique case (st)
      S_IDLE:   if (in_valid) st_next = S_DECODE;
      S_DECODE: begin
        if (phase == PH_RING) begin
          dreq.start = 1'b1;
          dreq.num   = {slice_counter, 32'd0};
          dreq.den   = n;
          st_next    = S_DTH;
        end else begin
          st_next = S_OUT;
        end
      end
      S_DTH: if (!dbusy && started) begin
        dreq.start = 1'b1;
        dreq.num   = {1'b0, ring_counter, 31'd0};
        dreq.den   = sk;
        st_next    = S_DPH;
      end
      S_DPH: if (!dbusy && started) begin
        dreq.start = 1'b1;
        dreq.num   = 40'({slice_counter, 16'd0}) + 40'(n[7:1]);
        dreq.den   = n;
        st_next    = S_DU;
      end
      S_DU: if (!dbusy && started) begin
        dreq.start = 1'b1;
        dreq.num   = 40'({ring_counter, 16'd0}) + 40'(sk[7:1]);
        dreq.den   = sk;
        st_next    = S_DV;
      end
      S_DV: if (!dbusy && started) begin
        cstart  = 1'b1;
        cang    = th;
        st_next = S_CTH;
      end
      S_CTH: if (!cbusy && started) begin
        cstart  = 1'b1;
        cang    = ph;
        st_next = S_CPH;
      end
      S_CPH: if (!cbusy && started) st_next = S_M0;
      S_M0: begin ma = sp; mb = ct; st_next = S_M1; end
      S_M1: begin ma = sp; mb = stt; st_next = S_M2; end
      S_M2: begin ma = $signed({1'b0, radius}); mb = nx; st_next = S_M3; end
      S_M3: begin ma = $signed({1'b0, radius}); mb = cp; st_next = S_M4; end
      S_M4: begin ma = $signed({1'b0, radius}); mb = nz; st_next = S_OUT; end
      S_OUT: if (out_ready) st_next = S_IDLE;
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      started <= 1'b0;
    end else begin
      st <= st_next;
      // hold off the wait states on entry, while started is still low after a state change
      started <= (st_next == st);
    end
  end

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 16'd256;
      slice_count <= 8'd16;
      stack_count <= 8'd16;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RADIUS: radius <= cfg_data;
        CFG_SLICES: slice_count <= cfg_data[7:0];
        CFG_STACKS: stack_count <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // counters and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TOP;
      ring_counter <= 8'd0;
      slice_counter <= 8'd0;
      corner_counter <= 3'd0;
    end else if (st == S_IDLE && in_valid && restart) begin
      phase <= PH_TOP;
      ring_counter <= 8'd0;
      slice_counter <= 8'd0;
      corner_counter <= 3'd0;
    end else if (st == S_OUT && out_ready) begin
      unique case (phase)
        PH_TOP: begin
          phase <= PH_RING; ring_counter <= 8'd1; slice_counter <= 8'd0;
        end
        PH_RING: begin
          if (slice_counter >= n) begin
            slice_counter <= 8'd0;
            if (ring_counter >= sk - 8'd1) phase <= PH_BOT;
            else ring_counter <= ring_counter + 8'd1;
          end else slice_counter <= slice_counter + 8'd1;
        end
        PH_BOT: begin
          phase <= PH_TFAN; slice_counter <= 8'd0; corner_counter <= 3'd0;
        end
        PH_TFAN, PH_BFAN: begin
          if (corner_counter >= 3'd2) begin
            corner_counter <= 3'd0;
            if (slice_counter >= n - 8'd1) begin
              slice_counter <= 8'd0;
              ring_counter <= 8'd0;
              if (phase == PH_BFAN) phase <= PH_DONE;
              else phase <= (sk > 8'd2) ? PH_BAND : PH_BFAN;
            end else slice_counter <= slice_counter + 8'd1;
          end else corner_counter <= corner_counter + 3'd1;
        end
        PH_BAND: begin
          if (corner_counter >= 3'd5) begin
            corner_counter <= 3'd0;
            if (slice_counter >= n - 8'd1) begin
              slice_counter <= 8'd0;
              if ({1'b0, ring_counter} >= {1'b0, sk} - 9'd3) phase <= PH_BFAN;
              else ring_counter <= ring_counter + 8'd1;
            end else slice_counter <= slice_counter + 8'd1;
          end else corner_counter <= corner_counter + 3'd1;
        end
        default: phase <= PH_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st)
      S_DECODE: begin
        {o_px, o_py, o_pz, o_nx, o_ny, o_nz, o_tx, o_tz, o_u, o_v, o_idx} <= '0;
        unique case (phase)
          PH_TOP, PH_BOT: begin
            o_kind <= KIND_VERTEX;
            o_py <= (phase == PH_TOP) ? $signed({1'b0, radius})
                                       : -$signed({1'b0, radius});
            o_ny <= (phase == PH_TOP) ? 16'sd16384 : -16'sd16384;
            o_tx <= 16'sd16384;
            o_v  <= (phase == PH_TOP) ? 17'd0 : 17'd65536;
          end
          PH_RING: o_kind <= KIND_VERTEX;
          PH_TFAN, PH_BAND, PH_BFAN: begin
            o_kind <= KIND_INDEX;
            o_idx  <= cidx;
          end
          default: o_kind <= KIND_DONE;
        endcase
      end
      S_DTH: if (!dbusy && started) th <= dq[31:0];
      S_DPH: if (!dbusy && started) ph <= dq[31:0];
      S_DU:  if (!dbusy && started) o_u <= dq[16:0];
      S_DV:  if (!dbusy && started) o_v <= dq[16:0];
      S_CTH: if (!cbusy && started) begin
        ct <= ccos;
        stt <= csin;
        o_tx <= 16'(-csin);
        o_tz <= ccos[15:0];
      end
      S_CPH: if (!cbusy && started) begin
        cp <= ccos;
        sp <= csin;
        o_ny <= ccos[15:0];
      end
      S_M0: begin nx <= rnd[16:0]; o_nx <= rnd[15:0]; end
      S_M1: begin nz <= rnd[16:0]; o_nz <= rnd[15:0]; end
      S_M2: o_px <= rnd[16:0];
      S_M3: o_py <= rnd[16:0];
      S_M4: o_pz <= rnd[16:0];
      default: ;
    endcase
  end

  assign out_valid    = (st == S_OUT);
  assign kind         = o_kind;
  assign pos_x        = o_px;
  assign pos_y        = o_py;
  assign pos_z        = o_pz;
  assign nrm_x        = o_nx;
  assign nrm_y        = o_ny;
  assign nrm_z        = o_nz;
  assign tan_x        = o_tx;
  assign tan_z        = o_tz;
  assign tex_u        = o_u;
  assign tex_v        = o_v;
  assign vertex_index = o_idx;

  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    st == S_IDLE |-> !dbusy && !cbusy) else $error("unit busy in idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(vertex_index))
    else $error("result dropped");
  a_kind_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind != 2'd3) else $error("bad kind");

endmodule

/* rtl/core/uvs_div.sv */
// ----------------------------------------------------------------------------
// UV sphere divider
// Restoring radix-2 divider, one quotient bit per cycle, 8 bit divisor.
// ----------------------------------------------------------------------------
module uvs_div
  import uvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        busy,
  output logic [39:0] quot
);

  logic [5:0]  cnt;
  logic [39:0] num;
  logic [8:0]  rem;
  logic [7:0]  den;
  logic [8:0]  trial;

  assign busy  = (cnt != 6'd0);
  assign trial = {rem[7:0], num[39]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 6'd0;
    end else if (req.start) begin
      cnt <= 6'd40;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num  <= req.num;
      den  <= req.den;
      rem  <= 9'd0;
      quot <= 40'd0;
    end else if (busy) begin
      num <= {num[38:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem  <= trial - {1'b0, den};
        quot <= {quot[38:0], 1'b1};
      end else begin
        rem  <= trial;
        quot <= {quot[38:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/core/uvs_cordic.sv */
// ----------------------------------------------------------------------------
// UV sphere CORDIC
// Rotation-mode CORDIC, one micro-rotation per cycle; returns Q2.14 cos, sin.
// ----------------------------------------------------------------------------
module uvs_cordic
  import uvs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               busy,
  output logic signed [16:0] cos_o,
  output logic signed [16:0] sin_o
);

  logic [4:0]         step;
  logic               run;
  logic [1:0]         quad;
  logic signed [33:0] x, y;
  logic signed [32:0] z;
  logic signed [33:0] dx, dy;
  logic signed [16:0] cr, sr;

  assign busy = run;
  assign dx = y >>> step;
  assign dy = x >>> step;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      step <= 5'd0;
    end else if (start) begin
      run  <= 1'b1;
      step <= 5'd0;
    end else if (run) begin
      if (step == 5'(CordicSteps - 1)) run <= 1'b0;
      step <= step + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CordicGain;
      y    <= 34'sd0;
      z    <= {3'b000, angle[29:0]};
      quad <= angle[31:30];
    end else if (run) begin
      if (!z[32]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - $signed({3'b000, atan_turn(step)});
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + $signed({3'b000, atan_turn(step)});
      end
    end
  end

  function automatic logic signed [16:0] to_q14(input logic signed [33:0] v);
    logic signed [33:0] r;
    begin
      r = (v + 34'sd32768) >>> 16;
      if (r > 34'sd16384) r = 34'sd16384;
      if (r < -34'sd16384) r = -34'sd16384;
      return r[16:0];
    end
  endfunction

  always_comb begin
    cr = to_q14(x);
    sr = to_q14(y);
    case (quad)
      2'd0:    begin cos_o = cr;  sin_o = sr;  end
      2'd1:    begin cos_o = -sr; sin_o = cr;  end
      2'd2:    begin cos_o = -cr; sin_o = -sr; end
      default: begin cos_o = sr;  sin_o = -cr; end
    endcase
  end

endmodule
